// File: rtl/ksel_pkg.sv
// Package for the k-smallest selector.
// Shared data width and the queue status type; no dependencies.
package ksel_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    typedef struct packed {
        logic full;
        logic empty;
    } t_ksel_qstat;

endpackage

// File: rtl/ksel_front.sv
// Front end of the k-smallest selector: sorted compare-cell chain.
// Inserts one value per cycle while the queue is not full and hands a
// snapshot to the queue at set end. Depends on ksel_pkg.
module ksel_front
    import ksel_pkg::*;
#(
    parameter int MAX_KEPT = 16,
    localparam int CW = $clog2(MAX_KEPT + 1),
    localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [CW-1:0]                    i_k,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [DATA_W-1:0]         i_value,
    input  logic                             i_last,
    input  t_ksel_qstat                      i_qstat,
    output logic                             o_push,
    output logic [MAX_KEPT-1:0][DATA_W-1:0]  o_vals,
    output logic [CW-1:0]                    o_k,
    output logic                             o_too_few
);

    logic [MAX_KEPT-1:0][DATA_W-1:0] r_vals;
    logic [MAX_KEPT-1:0][DATA_W-1:0] n_vals;
    logic [CW-1:0]                   r_occ;
    logic [CW-1:0]                   n_occ;
    logic [CW-1:0]                   held;
    logic [CW-1:0]                   ins_m;
    logic [CW-1:0]                   top_idx;
    logic [CW-1:0]                   n_cnt;
    logic [MAX_KEPT-1:0]             big;
    logic                            room;
    logic                            do_ins;
    logic                            accept;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        held    = (r_occ > i_k) ? i_k : r_occ;
        room    = (held < i_k);
        top_idx = i_k - CW'(1);
        do_ins  = room || ($signed(r_vals[top_idx[IW-1:0]]) > i_value);
        ins_m   = room ? held : top_idx;
        n_cnt   = room ? held + CW'(1) : held;
        for (int i = 0; i < MAX_KEPT; i++) begin
            big[i] = (CW'(i) >= ins_m) || ($signed(r_vals[i]) > i_value);
        end
        for (int i = 0; i < MAX_KEPT; i++) begin
            if (!do_ins || !big[i]) begin
                n_vals[i] = r_vals[i];
            end else if (i > 0 && big[(i > 0) ? i - 1 : 0]) begin
                n_vals[i] = r_vals[(i > 0) ? i - 1 : 0];
            end else begin
                n_vals[i] = i_value;
            end
        end
        n_occ = i_last ? '0 : n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (accept) begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vals <= n_vals;
        end
    end

    assign o_push    = accept && i_last;
    assign o_vals    = n_vals;
    assign o_k       = i_k;
    assign o_too_few = (n_cnt < i_k);

endmodule

// File: rtl/ksel_queue.sv
// Two-entry queue of set snapshots between front and back end.
// Depends on ksel_pkg.
module ksel_queue
    import ksel_pkg::*;
#(
    parameter int MAX_KEPT = 16,
    localparam int CW = $clog2(MAX_KEPT + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [MAX_KEPT-1:0][DATA_W-1:0]  i_vals,
    input  logic [CW-1:0]                    i_k,
    input  logic                             i_too_few,
    input  logic                             i_pop,
    output t_ksel_qstat                      o_qstat,
    output logic [MAX_KEPT-1:0][DATA_W-1:0]  o_vals,
    output logic [CW-1:0]                    o_k,
    output logic                             o_too_few
);

    logic [1:0][MAX_KEPT-1:0][DATA_W-1:0] r_vals;
    logic [1:0][CW-1:0]                   r_k;
    logic [1:0]                           r_too_few;
    logic                                 r_wr;
    logic                                 r_rd;
    logic [1:0]                           r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_vals[r_wr]    <= i_vals;
            r_k[r_wr]       <= i_k;
            r_too_few[r_wr] <= i_too_few;
        end
    end

    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);
    assign o_vals        = r_vals[r_rd];
    assign o_k           = r_k[r_rd];
    assign o_too_few     = r_too_few[r_rd];

endmodule

// File: rtl/ksel_back.sv
// Back end of the k-smallest selector: walks the queue head largest first
// into a registered output stage. Depends on ksel_pkg.
module ksel_back
    import ksel_pkg::*;
#(
    parameter int MAX_KEPT = 16,
    localparam int CW = $clog2(MAX_KEPT + 1),
    localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_ksel_qstat                      i_qstat,
    input  logic [MAX_KEPT-1:0][DATA_W-1:0]  i_vals,
    input  logic [CW-1:0]                    i_k,
    input  logic                             i_too_few,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [DATA_W-1:0]                o_data,
    output logic                             o_last,
    output logic                             o_too_few
);

    logic [CW-1:0]     r_pos;
    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              r_last;
    logic              r_too_few;
    logic [CW-1:0]     rd_idx;
    logic              advance;
    logic              emit;
    logic              burst_end;

    assign advance   = !r_valid || i_ready;
    assign emit      = advance && !i_qstat.empty;
    assign rd_idx    = i_k - CW'(1) - r_pos;
    assign burst_end = i_too_few || (r_pos == i_k - CW'(1));
    assign o_pop     = emit && burst_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (advance) begin
            r_valid <= emit;
            if (emit) begin
                r_pos <= burst_end ? '0 : r_pos + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data    <= i_too_few ? '0 : i_vals[rd_idx[IW-1:0]];
            r_last    <= burst_end;
            r_too_few <= i_too_few;
        end
    end

    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign o_last    = r_last;
    assign o_too_few = r_too_few;

endmodule

// File: rtl/k_smallest_selector.sv
// Top level of the k-smallest selector: config register, front end, queue, back end.
// Depends on ksel_pkg, ksel_front, ksel_queue, ksel_back.
//
// Usage:
//   Slave stream: one signed 32-bit value per transaction, tlast on the last
//   value of a set. Master stream: the k smallest values of the set, largest
//   first, tlast on the final one; tuser flags a set shorter than k, sent as
//   a single transaction with data zero.
//   Config channel: write k (5 bits, reset 4; 0 acts as 1, values above
//   MAX_KEPT act as MAX_KEPT) only while the block is idle.
//   Throughput: one input value per cycle while the queue has a free entry;
//   the compare-cell chain computes each insertion combinationally and stores
//   it on the accepting edge. Output runs one result per cycle while the
//   receiver is ready. A set's snapshot is written into the queue on the edge
//   that takes its last value; its results are loaded from the queue head.
//   A two-entry snapshot queue separates input from output: values keep
//   flowing while a burst drains, and input stalls only when both entries
//   are waiting. A stalled receiver holds the output register.
//   Reset clears the store, the queue and the output; k returns to 4.
module k_smallest_selector
    import ksel_pkg::*;
#(
    parameter int MAX_KEPT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [31:0]       i_s_axis_tdata,   // [31:0] sample_value
    input  logic              i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,   // [31:0] kept_value
    output logic              o_m_axis_tlast,
    output logic              o_m_axis_tuser,   // [0] too_few
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0]                r_k_count;
    logic [EW-1:0]                   k_wide;
    logic [CW-1:0]                   k_eff;
    t_ksel_qstat                     qstat;
    logic                            push;
    logic                            pop;
    logic [MAX_KEPT-1:0][DATA_W-1:0] f_vals;
    logic [MAX_KEPT-1:0][DATA_W-1:0] q_vals;
    logic [CW-1:0]                   f_k;
    logic [CW-1:0]                   q_k;
    logic                            f_too_few;
    logic                            q_too_few;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_count <= CFG_W'(4);
        end else if (i_cfg_valid) begin
            r_k_count <= i_cfg_data;
        end
    end

    always_comb begin
        k_wide = EW'(r_k_count);
        if (k_wide == '0) begin
            k_wide = EW'(1);
        end else if (k_wide > EW'(MAX_KEPT)) begin
            k_wide = EW'(MAX_KEPT);
        end
        k_eff = k_wide[CW-1:0];
    end

    ksel_front #(.MAX_KEPT(MAX_KEPT)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_k       (k_eff),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_value   ($signed(i_s_axis_tdata)),
        .i_last    (i_s_axis_tlast),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_vals    (f_vals),
        .o_k       (f_k),
        .o_too_few (f_too_few)
    );

    ksel_queue #(.MAX_KEPT(MAX_KEPT)) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_vals    (f_vals),
        .i_k       (f_k),
        .i_too_few (f_too_few),
        .i_pop     (pop),
        .o_qstat   (qstat),
        .o_vals    (q_vals),
        .o_k       (q_k),
        .o_too_few (q_too_few)
    );

    ksel_back #(.MAX_KEPT(MAX_KEPT)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_qstat   (qstat),
        .i_vals    (q_vals),
        .i_k       (q_k),
        .i_too_few (q_too_few),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast),
        .o_too_few (o_m_axis_tuser)
    );

endmodule
